FILE: hw/rtl/msacc_pkg.sv
// Shared types and constants for the alignment column conservation block.
// Holds the input/output item structs, the column job passed front to back,
// and fixed widths. No dependencies.
package msacc_pkg;

    // Fixed field and state widths
    localparam int CNT_W   = 11;  // per-letter counts, residues per column
    localparam int SUM_W   = 33;  // running conservation sum
    localparam int COLS_W  = 17;  // non-gap column count
    localparam int Q16_W   = 17;  // Q16 result, 65536 = 1.0
    localparam int CFG_W   = 6;   // alphabet_size register
    localparam int LTR_W   = 5;   // letter index

    localparam logic [Q16_W-1:0] Q16_ONE     = 17'h10000;
    localparam logic [CFG_W-1:0] ALPHA_RESET = 6'd20;
    localparam logic [CNT_W-1:0] CNT_SAT     = 11'd2047;
    localparam logic [COLS_W-1:0] COLS_SAT   = 17'd131071;
    localparam logic [SUM_W-1:0] SUM_SAT     = {SUM_W{1'b1}};

    // One residue of the alignment
    typedef struct packed {
        logic [LTR_W-1:0] letter;
        logic             is_gap;
        logic             is_wildcard;
        logic             column_end;
        logic             alignment_end;
    } t_in_item;

    // One column result
    typedef struct packed {
        logic [Q16_W-1:0] column_cons;
        logic             column_all_gap;
        logic             average_valid;
        logic [Q16_W-1:0] average_cons;
        logic             no_columns_error;
    } t_out_item;

    // Column summary handed from the counting front to the divide back
    typedef struct packed {
        logic [CNT_W-1:0] max_count;
        logic [CNT_W-1:0] residues;
        logic             all_gap;
        logic             aln_end;
    } t_col_job;

endpackage

FILE: hw/rtl/msacc_front.sv
// Counting front: per-column letter histogram, highest count and residue count.
// Emits one column summary job per column end. Depends on msacc_pkg.
module msacc_front
    import msacc_pkg::*;
#(
    parameter int ALPHA_MAX = 32,
    parameter int MAX_SEQS  = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_item         i_item,
    input  logic [CFG_W-1:0] i_alpha_size,
    output logic             o_push,
    output t_col_job         o_job
);

    localparam int AW = $clog2(ALPHA_MAX);
    localparam logic [CNT_W-1:0] CNT_LIMIT =
        (MAX_SEQS < 2047) ? CNT_W'(MAX_SEQS) : CNT_SAT;
    localparam logic [CFG_W-1:0] ALPHA_LIM = CFG_W'(ALPHA_MAX);

    logic [CNT_W-1:0] r_counts [ALPHA_MAX];
    logic [CNT_W-1:0] r_max, n_max;
    logic [CNT_W-1:0] r_res, n_res;
    logic             r_all_gap, n_all_gap;

    logic [CFG_W-1:0] limit;
    logic             hit;
    logic             col_done;
    logic [AW-1:0]    idx;
    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] new_cnt;

    // Classify the residue and compute the updated column state
    always_comb begin
        limit    = (i_alpha_size < ALPHA_LIM) ? i_alpha_size : ALPHA_LIM;
        idx      = i_item.letter[AW-1:0];
        hit      = !i_item.is_gap && !i_item.is_wildcard &&
                   ({1'b0, i_item.letter} < limit);
        col_done = i_item.column_end || i_item.alignment_end;
        cur_cnt  = hit ? r_counts[idx] : '0;
        new_cnt  = (cur_cnt < CNT_LIMIT) ? cur_cnt + 1'b1 : cur_cnt;

        n_res     = (r_res < CNT_LIMIT) ? r_res + 1'b1 : r_res;
        n_all_gap = r_all_gap && i_item.is_gap;
        n_max     = (hit && new_cnt > r_max) ? new_cnt : r_max;
    end

    // Summary goes out on the column's last residue
    assign o_push          = i_accept && col_done;
    assign o_job.max_count = n_max;
    assign o_job.residues  = n_res;
    assign o_job.all_gap   = n_all_gap;
    assign o_job.aln_end   = i_item.alignment_end;

    // Histogram entries: clear at column end, bump the hit letter otherwise
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ALPHA_MAX; i++) begin
            if (!i_rst_n) begin
                r_counts[i] <= '0;
            end else if (i_accept) begin
                if (col_done) begin
                    r_counts[i] <= '0;
                end else if (hit && idx == AW'(i)) begin
                    r_counts[i] <= new_cnt;
                end
            end
        end
    end

    // Column scalars
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= '0;
            r_res     <= '0;
            r_all_gap <= 1'b1;
        end else if (i_accept) begin
            if (col_done) begin
                r_max     <= '0;
                r_res     <= '0;
                r_all_gap <= 1'b1;
            end else begin
                r_max     <= n_max;
                r_res     <= n_res;
                r_all_gap <= n_all_gap;
            end
        end
    end

endmodule

FILE: hw/rtl/msacc_queue.sv
// Two-entry queue of column jobs between the front and the back.
// Depends on msacc_pkg.
module msacc_queue
    import msacc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_col_job i_job,
    input  logic     i_pop,
    output t_col_job o_job,
    output logic     o_full,
    output logic     o_empty
);

    t_col_job   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/msacc_div.sv
// Restoring divider, one quotient bit per cycle, SUM_W-bit dividend over
// a COLS_W-bit divisor. Depends on msacc_pkg.
module msacc_div
    import msacc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [COLS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SUM_W-1:0]  o_quotient
);

    localparam int CW = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_dvd;
    logic [SUM_W-1:0]  r_quo;
    logic [COLS_W-1:0] r_dvs;
    logic [COLS_W-1:0] r_rem;
    logic [CW-1:0]     r_cnt;
    logic              r_done;

    logic [COLS_W:0]   rem_sh;
    logic              q_bit;
    logic [COLS_W:0]   rem_sub;

    // One restoring step
    always_comb begin
        rem_sh  = {r_rem, r_dvd[SUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
        rem_sub = q_bit ? rem_sh - {1'b0, r_dvs} : rem_sh;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[SUM_W-2:0], 1'b0};
            r_rem <= rem_sub[COLS_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
    end

    // Step counter and finish pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(SUM_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/msacc_back.sv
// Divide back: column conservation, running average and the output register.
// Depends on msacc_pkg and msacc_div.
module msacc_back
    import msacc_pkg::*;
#(
    parameter int MAX_COLS = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_col_job  i_job,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [COLS_W-1:0] COL_LIMIT =
        (MAX_COLS < 131071) ? COLS_W'(MAX_COLS) : COLS_SAT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_COL,
        S_ACC,
        S_DIV_AVG,
        S_OUT
    } t_state;

    t_state             r_state;
    t_col_job           r_job;
    logic [Q16_W-1:0]   r_cons;
    logic [Q16_W-1:0]   r_avg;
    logic               r_err;
    logic [SUM_W-1:0]   r_sum;
    logic [COLS_W-1:0]  r_cols;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [COLS_W-1:0]  div_divisor;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;

    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   n_sum;
    logic [COLS_W-1:0]  n_cols;
    logic [Q16_W-1:0]   quo_clamp;
    logic               out_free;

    msacc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Saturating accumulation for a non-gap column
    always_comb begin
        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_cons);
        if (r_job.all_gap) begin
            n_sum  = r_sum;
            n_cols = r_cols;
        end else begin
            n_sum  = sum_add[SUM_W] ? SUM_SAT : sum_add[SUM_W-1:0];
            n_cols = (r_cols < COL_LIMIT) ? r_cols + 1'b1 : r_cols;
        end
        quo_clamp = (div_quo > SUM_W'(Q16_ONE)) ? Q16_ONE : div_quo[Q16_W-1:0];
        out_free  = !r_out_valid || !i_out_stall;
    end

    // Divider launch: column ratio from the queue head, average after accumulate
    always_comb begin
        div_start    = 1'b0;
        div_dividend = SUM_W'({i_job.max_count, 16'h0000});
        div_divisor  = COLS_W'(i_job.residues);
        o_pop        = (r_state == S_IDLE) && !i_empty;
        if (o_pop && i_job.max_count != '0) begin
            div_start = 1'b1;
        end
        if (r_state == S_ACC) begin
            div_dividend = n_sum;
            div_divisor  = n_cols;
            div_start    = r_job.aln_end && (n_cols != '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_cols      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Result valid: set when a result is loaded, dropped once taken
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_avg <= '0;
                        r_err <= 1'b0;
                        if (i_job.max_count == '0) begin
                            r_cons  <= Q16_ONE;
                            r_state <= S_ACC;
                        end else begin
                            r_state <= S_DIV_COL;
                        end
                    end
                end
                S_DIV_COL: begin
                    if (div_done) begin
                        r_cons  <= quo_clamp;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sum  <= n_sum;
                    r_cols <= n_cols;
                    if (r_job.aln_end && n_cols != '0) begin
                        r_state <= S_DIV_AVG;
                    end else begin
                        r_err   <= r_job.aln_end;
                        r_state <= S_OUT;
                    end
                end
                S_DIV_AVG: begin
                    if (div_done) begin
                        r_avg   <= quo_clamp;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.column_cons      <= r_cons;
                        r_out.column_all_gap   <= r_job.all_gap;
                        r_out.average_valid    <= r_job.aln_end;
                        r_out.average_cons     <= r_avg;
                        r_out.no_columns_error <= r_err;
                        if (r_job.aln_end) begin
                            r_sum  <= '0;
                            r_cols <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/msa_column_conservation_top.sv
// Top level of the alignment column conservation block: alphabet register,
// counting front, job queue and divide back. Depends on msacc_pkg and submodules.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | into      | i_in_valid/o_in_stall | i_in_data  (t_in_item)
//  out     | out of    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//  cfg     | into      | i_cfg_valid/o_cfg_ready | i_cfg_data (alphabet_size)
//
// The front takes one residue per cycle while the job queue has room; the
// histogram read-increment-write of a letter count sets that step. Each column
// end queues a job; the back takes the job, runs its bit-serial divider,
// accumulates and loads the result; it skips the divider when no letter was
// counted, and on the last column divides again for the average. Input stalls
// only when the two-entry job queue is full. Reset is synchronous and clears all
// counts; the result register holds its item while i_out_stall is high.
module msa_column_conservation_top
    import msacc_pkg::*;
#(
    parameter int ALPHA_MAX = 32,
    parameter int MAX_SEQS  = 1024,
    parameter int MAX_COLS  = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_alpha_size;
    logic             in_accept;
    logic             push;
    t_col_job         push_job;
    t_col_job         head_job;
    logic             q_full;
    logic             q_empty;
    logic             pop;

    // Alphabet size register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_size <= ALPHA_RESET;
        end else if (i_cfg_valid) begin
            r_alpha_size <= i_cfg_data;
        end
    end

    // Input flow control
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    msacc_front #(
        .ALPHA_MAX (ALPHA_MAX),
        .MAX_SEQS  (MAX_SEQS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_data),
        .i_alpha_size (r_alpha_size),
        .o_push       (push),
        .o_job        (push_job)
    );

    msacc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    msacc_back #(
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: bench/msa_column_conservation_checker.sv
// Scoreboard for msa_column_conservation_top: watches the residue, result and
// alphabet channels, predicts every column result and compares it field by field.
// Depends on msacc_pkg.
module msa_column_conservation_checker
    import msacc_pkg::*;
#(
    parameter int ALPHA_MAX = 32,
    parameter int MAX_SEQS  = 1024,
    parameter int MAX_COLS  = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out_data,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    // Saturation points of the counters
    localparam int TALLY_CAP  = (MAX_SEQS < 2047) ? MAX_SEQS : 2047;
    localparam int COLUMN_CAP = (MAX_COLS < 131071) ? MAX_COLS : 131071;

    // Shadow state of the block
    logic [CFG_W-1:0]  alpha_size;
    logic [CNT_W-1:0]  letter_tally [ALPHA_MAX];
    logic [CNT_W-1:0]  peak_tally;
    logic [CNT_W-1:0]  column_depth;
    logic              only_gaps;
    logic [SUM_W-1:0]  cons_total;
    logic [COLS_W-1:0] scored_columns;
    t_out_item         expected_columns [$];

    task automatic note_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("checker: column result mismatch, %s: got %0d, expected %0d",
                 field, got, want);
        o_fail_count++;
    endtask

    task automatic clear_column();
        foreach (letter_tally[k]) letter_tally[k] = '0;
        peak_tally   = '0;
        column_depth = '0;
        only_gaps    = 1'b1;
    endtask

    // Count one residue; on a column end queue the column's conservation
    task automatic score_residue(input t_in_item r);
        int          span;
        logic [63:0] ratio;
        logic [63:0] total;
        t_out_item   res;
        span = (int'(alpha_size) < ALPHA_MAX) ? int'(alpha_size) : ALPHA_MAX;
        if (column_depth < TALLY_CAP) column_depth++;
        if (!r.is_gap) begin
            only_gaps = 1'b0;
            if (!r.is_wildcard && int'(r.letter) < span) begin
                if (letter_tally[r.letter] < TALLY_CAP) letter_tally[r.letter]++;
                if (letter_tally[r.letter] > peak_tally) peak_tally = letter_tally[r.letter];
            end
        end
        if (!r.column_end && !r.alignment_end) return;

        res = '0;
        if (peak_tally == 0 || column_depth == 0) begin
            res.column_cons = Q16_ONE;
        end else begin
            ratio = (64'(peak_tally) << 16) / 64'(column_depth);
            res.column_cons = (ratio > 64'(Q16_ONE)) ? Q16_ONE : Q16_W'(ratio);
        end
        res.column_all_gap = only_gaps;

        // all-gap columns stay out of the average
        if (!only_gaps) begin
            total = 64'(cons_total) + 64'(res.column_cons);
            cons_total = (total > 64'(SUM_SAT)) ? SUM_SAT : SUM_W'(total);
            if (scored_columns < COLUMN_CAP) scored_columns++;
        end

        if (r.alignment_end) begin
            res.average_valid = 1'b1;
            if (scored_columns == 0) begin
                res.no_columns_error = 1'b1;
            end else begin
                ratio = 64'(cons_total) / 64'(scored_columns);
                res.average_cons = (ratio > 64'(Q16_ONE)) ? Q16_ONE : Q16_W'(ratio);
            end
            cons_total     = '0;
            scored_columns = '0;
        end
        expected_columns.push_back(res);
        clear_column();
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_columns.size() == 0) begin
            note_mismatch("result with none expected, column_cons", got.column_cons, 0);
            return;
        end
        want = expected_columns.pop_front();
        if (got.column_cons !== want.column_cons)
            note_mismatch("column_cons", got.column_cons, want.column_cons);
        if (got.column_all_gap !== want.column_all_gap)
            note_mismatch("column_all_gap", got.column_all_gap, want.column_all_gap);
        if (got.average_valid !== want.average_valid)
            note_mismatch("average_valid", got.average_valid, want.average_valid);
        if (got.average_cons !== want.average_cons)
            note_mismatch("average_cons", got.average_cons, want.average_cons);
        if (got.no_columns_error !== want.no_columns_error)
            note_mismatch("no_columns_error", got.no_columns_error, want.no_columns_error);
    endtask

    // Results are compared before the same edge's residue is counted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            alpha_size     = ALPHA_RESET;
            cons_total     = '0;
            scored_columns = '0;
            clear_column();
            expected_columns.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result(i_out_data);
            if (i_cfg_valid && i_cfg_ready) alpha_size = i_cfg_data;
            if (i_in_valid && !i_in_stall) score_residue(i_in_data);
        end
        o_pending = expected_columns.size();
    end

endmodule

FILE: bench/msa_column_conservation_top_tb.sv
// Testbench top for msa_column_conservation_top: drives residues, alphabet writes
// and result back-pressure, and gives the verdict from the checker's count.
// Depends on msacc_pkg, msa_column_conservation_top and msa_column_conservation_checker.
module msa_column_conservation_top_tb;
    import msacc_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SEG_ITEMS   = 42;
    localparam int SAT_DEPTH   = 1100;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in_item         in_data;
    logic             out_valid;
    logic             out_stall;
    t_out_item        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int fail_count;
    int pending_columns;
    int src_idle_pct;
    int sink_stall_pct;
    int sent_count;
    int quiet_cycles;
    int alpha_now;

    msa_column_conservation_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    msa_column_conservation_checker column_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_columns)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random result back-pressure
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Watchdog: cycles with no item moving on any channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("msa_column_conservation_top verification failed");
            $finish;
        end
    end

    function automatic t_in_item residue(input int ltr, input bit gap, input bit wild,
                                         input bit cend, input bit aend);
        t_in_item r;
        r.letter        = LTR_W'(ltr);
        r.is_gap        = gap;
        r.is_wildcard   = wild;
        r.column_end    = cend;
        r.alignment_end = aend;
        return r;
    endfunction

    // Offer one item after random idle cycles; return at the accepting edge
    task automatic put_residue(input t_in_item r);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    // Stop sending and let every queued column come out
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_columns != 0) @(negedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic program_alpha(input int value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        alpha_now = value;
    endtask

    task automatic play_column(input int depth, input int gap_pct, input int wild_pct,
                               input bit closes_alignment);
        t_in_item r;
        int       span;
        int       favored;
        span = (alpha_now > 32) ? 32 : alpha_now;
        if (span > 0 && $urandom_range(3) != 0)
            favored = $urandom_range(0, span - 1);
        else
            favored = $urandom_range(0, 31);
        for (int k = 0; k < depth; k++) begin
            r.letter      = ($urandom_range(99) < 60) ? LTR_W'(favored)
                                                      : LTR_W'($urandom_range(0, 31));
            r.is_gap      = ($urandom_range(99) < gap_pct);
            r.is_wildcard = ($urandom_range(99) < wild_pct);
            r.column_end  = (k == depth - 1);
            r.alignment_end = closes_alignment && (k == depth - 1);
            // sometimes the alignment end alone closes the last column
            if (r.alignment_end && $urandom_range(7) == 0) r.column_end = 1'b0;
            put_residue(r);
        end
    endtask

    task automatic play_alignment(input int columns, input int depth_max);
        int  depth;
        int  gap_pct;
        bit  gaps_only;
        gaps_only = ($urandom_range(19) == 0);
        for (int c = 0; c < columns; c++) begin
            depth = ($urandom_range(9) == 0) ? $urandom_range(1, depth_max * 4)
                                             : $urandom_range(1, depth_max);
            gap_pct = (gaps_only || $urandom_range(9) == 0) ? 100 : $urandom_range(0, 30);
            play_column(depth, gap_pct, $urandom_range(0, 20), c == columns - 1);
        end
    endtask

    initial begin
        int       alpha_plan [6];
        int       seg_start;
        bit       paused;
        t_in_item r;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        src_idle_pct   = 34;
        sink_stall_pct = 66;
        sent_count     = 0;
        alpha_now      = ALPHA_RESET;
        alpha_plan     = '{1, 32, 0, 63, 0, 20};
        alpha_plan[4]  = $urandom_range(0, 63);
        paused         = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: out-of-range and wildcard letters, a gap with the wildcard flag set
        put_residue(residue(0, 0, 0, 0, 0));
        put_residue(residue(0, 0, 0, 0, 0));
        put_residue(residue(19, 0, 0, 0, 0));
        put_residue(residue(20, 0, 0, 0, 0));
        put_residue(residue(31, 1, 1, 0, 0));
        put_residue(residue(5, 0, 1, 1, 0));
        // all-gap column, then a column with no counted letter
        put_residue(residue(3, 1, 0, 0, 0));
        put_residue(residue(31, 1, 0, 1, 0));
        put_residue(residue(7, 0, 1, 0, 0));
        put_residue(residue(25, 0, 0, 1, 0));
        // alignment end without column end
        put_residue(residue(7, 0, 0, 0, 1));
        // alignment of gaps only gives the error flag
        put_residue(residue(0, 1, 0, 1, 1));
        put_residue(residue(12, 0, 0, 1, 1));
        // empty alphabet: every letter is a wildcard
        program_alpha(0);
        put_residue(residue(0, 0, 0, 0, 0));
        put_residue(residue(0, 0, 0, 1, 1));
        // oversized alphabet acts as the full 32 letters
        program_alpha(63);
        put_residue(residue(31, 0, 0, 0, 0));
        put_residue(residue(31, 0, 0, 0, 0));
        put_residue(residue(30, 0, 0, 1, 1));

        // Random alignments over several alphabet sizes and idling mixes
        for (int seg = 0; seg < 6; seg++) begin
            program_alpha(alpha_plan[seg]);
            case (seg / 2)
                0: begin
                    src_idle_pct   = 34;
                    sink_stall_pct = 66;
                end
                1: begin
                    src_idle_pct   = 66;
                    sink_stall_pct = 34;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            seg_start = sent_count;
            while (sent_count - seg_start < SEG_ITEMS) begin
                play_alignment($urandom_range(1, 8), 8);
                if (seg == 1 && !paused) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        // One deep column to push the residue and letter counters into saturation
        for (int k = 0; k < SAT_DEPTH; k++) begin
            r = residue(3, $urandom_range(99) < 3, 0, k == SAT_DEPTH - 1, k == SAT_DEPTH - 1);
            put_residue(r);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_columns != 0) @(negedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("msa_column_conservation_top verification clean");
        else
            $display("msa_column_conservation_top verification failed");
        $finish;
    end

endmodule

FILE: msa_column_conservation_top.f
hw/rtl/msacc_pkg.sv
hw/rtl/msacc_front.sv
hw/rtl/msacc_queue.sv
hw/rtl/msacc_div.sv
hw/rtl/msacc_back.sv
hw/rtl/msa_column_conservation_top.sv
bench/msa_column_conservation_checker.sv
bench/msa_column_conservation_top_tb.sv
